@@ sv/kcw_pkg.sv @@
// Shared constants, types and helper functions of the Koch segment walker.
package kcw_pkg;

  localparam int COORD_BITS    = 24;
  localparam int MAX_LEVELS    = 8;
  localparam int CNT_BITS      = 2 * MAX_LEVELS;
  localparam int DEPTH_BITS    = $clog2(MAX_LEVELS + 1);
  localparam int LVL_IDX_BITS  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LEVELS_BITS   = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;
  localparam int SIN60_BITS    = 17;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^COORD_BITS
  localparam logic [COORD_BITS-1:0] DIV3_MUL =
    COORD_BITS'(((64'd1 << (COORD_BITS + 1)) + 64'd2) / 64'd3);
  localparam int DIV3_SHIFT = COORD_BITS + 1;

  // sin(60) in Q16, kept positive in a signed operand
  localparam logic [SIN60_BITS-1:0] SIN60_Q16 = SIN60_BITS'(56756);

  localparam logic [DEPTH_BITS-1:0] MAX_DEPTH   = DEPTH_BITS'(MAX_LEVELS);
  localparam logic [MAX_LEVELS-1:0] FIRST_LEVEL = MAX_LEVELS'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [DEPTH_BITS-1:0]        depth_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } seg_t;

  typedef struct packed {
    logic       start;
    logic [1:0] digit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } walk_state_t;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_DIV,
    CP_SIN,
    CP_PT
  } cell_phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_END_X   = 3'd2,
    CFG_END_Y   = 3'd3,
    CFG_LEVELS  = 3'd4
  } cfg_idx_t;

  function automatic depth_t lvl_of(input int c);
    return DEPTH_BITS'(c + 1);
  endfunction

  function automatic cnt_t last_of(input depth_t d);
    logic [CNT_BITS:0] one_sh;
    logic [CNT_BITS:0] lst;
    one_sh = (CNT_BITS + 1)'(1) << {d, 1'b0};
    lst    = one_sh - 1'b1;
    return lst[CNT_BITS-1:0];
  endfunction

endpackage

@@ sv/kcw_in_if.sv @@
// Request channel: valid/ready with the restart flag.
interface kcw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

@@ sv/kcw_out_if.sv @@
// Result channel: valid/ready with one line segment word.
interface kcw_out_if;
  logic                   valid;
  logic                   ready;
  kcw_pkg::coord_t        from_x;
  kcw_pkg::coord_t        from_y;
  kcw_pkg::coord_t        to_x;
  kcw_pkg::coord_t        to_y;
  kcw_pkg::cnt_t          segment_number;
  logic                   last_segment;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  output segment_number, output last_segment, input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                  input segment_number, input last_segment, output ready);
endinterface

@@ sv/kcw_cell.sv @@
// One subdivision level: holds its segment and derives it from the parent through the divide, sin60 and point phases.
module kcw_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  kcw_pkg::cell_ctl_t ctl_i,
  input  kcw_pkg::seg_t      parent_i,
  output kcw_pkg::seg_t      seg_o,
  output logic               done_o
);

  kcw_pkg::cell_phase_t ph_r, ph_nxt;
  logic                 done_r;

  logic signed [kcw_pkg::COORD_BITS:0] diff_x, diff_y, ndiff_x, ndiff_y;
  logic [kcw_pkg::COORD_BITS-1:0]      mag_x_r, mag_y_r;
  logic                                neg_x_r, neg_y_r;

  logic [2*kcw_pkg::COORD_BITS-1:0]          prod_x, prod_y;
  logic [kcw_pkg::COORD_BITS-1:0]            q_x, q_y;
  kcw_pkg::coord_t                           dx_r, dy_r;

  logic signed [kcw_pkg::COORD_BITS+kcw_pkg::SIN60_BITS-1:0] sprod_x, sprod_y;
  kcw_pkg::coord_t                           sx_r, sy_r;

  kcw_pkg::coord_t x3, y3, x4, y4, x5, y5;
  kcw_pkg::seg_t   seg_r, seg_nxt;

  assign diff_x  = {parent_i.x2[kcw_pkg::COORD_BITS-1], parent_i.x2}
                 - {parent_i.x1[kcw_pkg::COORD_BITS-1], parent_i.x1};
  assign diff_y  = {parent_i.y2[kcw_pkg::COORD_BITS-1], parent_i.y2}
                 - {parent_i.y1[kcw_pkg::COORD_BITS-1], parent_i.y1};
  assign ndiff_x = -diff_x;
  assign ndiff_y = -diff_y;

  // divide by three toward zero on the magnitude
  assign prod_x = mag_x_r * kcw_pkg::DIV3_MUL;
  assign prod_y = mag_y_r * kcw_pkg::DIV3_MUL;
  assign q_x    = {1'b0, prod_x[2*kcw_pkg::COORD_BITS-1:kcw_pkg::DIV3_SHIFT]};
  assign q_y    = {1'b0, prod_y[2*kcw_pkg::COORD_BITS-1:kcw_pkg::DIV3_SHIFT]};

  assign sprod_x = dx_r * $signed(kcw_pkg::SIN60_Q16);
  assign sprod_y = dy_r * $signed(kcw_pkg::SIN60_Q16);

  assign x3 = parent_i.x1 + dx_r;
  assign y3 = parent_i.y1 + dy_r;
  assign x5 = parent_i.x2 - dx_r;
  assign y5 = parent_i.y2 - dy_r;
  assign x4 = x3 + (dx_r >>> 1) - sy_r;
  assign y4 = y3 + sx_r + (dy_r >>> 1);

  always_comb begin
    case (ctl_i.digit)
      2'd0:    seg_nxt = '{x1: parent_i.x1, y1: parent_i.y1, x2: x3, y2: y3};
      2'd1:    seg_nxt = '{x1: x3, y1: y3, x2: x4, y2: y4};
      2'd2:    seg_nxt = '{x1: x4, y1: y4, x2: x5, y2: y5};
      default: seg_nxt = '{x1: x5, y1: y5, x2: parent_i.x2, y2: parent_i.y2};
    endcase
  end

  always_comb begin
    case (ph_r)
      kcw_pkg::CP_IDLE: ph_nxt = ctl_i.start ? kcw_pkg::CP_DIV : kcw_pkg::CP_IDLE;
      kcw_pkg::CP_DIV:  ph_nxt = kcw_pkg::CP_SIN;
      kcw_pkg::CP_SIN:  ph_nxt = kcw_pkg::CP_PT;
      kcw_pkg::CP_PT:   ph_nxt = kcw_pkg::CP_IDLE;
      default:          ph_nxt = kcw_pkg::CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= kcw_pkg::CP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == kcw_pkg::CP_PT);
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == kcw_pkg::CP_IDLE && ctl_i.start) begin
      neg_x_r <= diff_x[kcw_pkg::COORD_BITS];
      neg_y_r <= diff_y[kcw_pkg::COORD_BITS];
      mag_x_r <= diff_x[kcw_pkg::COORD_BITS] ? ndiff_x[kcw_pkg::COORD_BITS-1:0]
                                             : diff_x[kcw_pkg::COORD_BITS-1:0];
      mag_y_r <= diff_y[kcw_pkg::COORD_BITS] ? ndiff_y[kcw_pkg::COORD_BITS-1:0]
                                             : diff_y[kcw_pkg::COORD_BITS-1:0];
    end
    if (ph_r == kcw_pkg::CP_DIV) begin
      dx_r <= neg_x_r ? -q_x : q_x;
      dy_r <= neg_y_r ? -q_y : q_y;
    end
    if (ph_r == kcw_pkg::CP_SIN) begin
      sx_r <= sprod_x[kcw_pkg::COORD_BITS+15:16];
      sy_r <= sprod_y[kcw_pkg::COORD_BITS+15:16];
    end
    if (ph_r == kcw_pkg::CP_PT) begin
      seg_r <= seg_nxt;
    end
  end

  assign seg_o  = seg_r;
  assign done_o = done_r;

endmodule

@@ sv/koch_curve_segment_walker_unit.sv @@
// Koch curve segment walker: top level with walk control and the chain of level cells.
//
// Usage: write the base segment (start_x, start_y, end_x, end_y) and the depth
// (levels, saturating at 8) through cfg_we/cfg_index/cfg_data while idle; a
// write to any of these five registers restarts the walk. Each request word on
// in_ch returns one segment word on out_ch in depth-first drawing order, with
// its number and a last flag. A request with restart set, the first after reset
// or such a write, and one after the last segment all begin at segment 0.
// On a restart all levels are recomputed, otherwise only the levels at and below
// the highest base-4 digit of the segment number that changed. Each level cell
// works in turn through difference, divide by three, sin60 product and point
// select, and hands its segment to the next cell. At depth 0 no level cell runs
// and the base segment is returned. The next request can be taken from the cycle
// after the result loads. Mostly only the deepest level changes. One request is
// in work at a time; the next is taken while the previous result waits in the
// output register. A stalled receiver holds the result and blocks the next one
// from leaving the chain.
// Reset clears the configuration registers, counter and handshake state; no clearing pass.
module koch_curve_segment_walker_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  kcw_in_if.sink                             in_ch,
  kcw_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [kcw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [kcw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  kcw_pkg::coord_t                     start_x_r, start_y_r, end_x_r, end_y_r;
  logic [kcw_pkg::LEVELS_BITS-1:0]     levels_r;
  kcw_pkg::depth_t                     depth, out_idx;

  kcw_pkg::walk_state_t state_r, state_nxt;
  logic                 started_r;
  kcw_pkg::cnt_t        counter_r, last, cnt_inc, n_nxt, diff;
  logic                 last_flag_r;
  logic                 accept, wrap, in_ready, out_free, load_out, fin;

  logic [kcw_pkg::MAX_LEVELS-1:0][1:0] diff_dig, cnt_dig;
  logic [kcw_pkg::MAX_LEVELS-1:0]      changed, sel, kick_nxt, kick_r, done, fin_v;

  kcw_pkg::cell_ctl_t ctl  [kcw_pkg::MAX_LEVELS];
  kcw_pkg::seg_t      segs [kcw_pkg::MAX_LEVELS];
  kcw_pkg::seg_t      base_seg_r, result_seg, out_seg_r;
  kcw_pkg::cnt_t      out_num_r;
  logic               out_valid_r, out_last_r;

  assign depth = (levels_r > kcw_pkg::MAX_LEVELS) ? kcw_pkg::MAX_DEPTH
                                                 : levels_r[kcw_pkg::DEPTH_BITS-1:0];
  assign last  = kcw_pkg::last_of(depth);

  assign accept  = in_ch.valid & in_ready;
  assign wrap    = in_ch.restart | ~started_r | (counter_r >= last);
  assign cnt_inc = counter_r + 1'b1;
  assign n_nxt   = wrap ? '0 : cnt_inc;
  assign diff    = n_nxt ^ counter_r;
  assign diff_dig = diff;
  assign cnt_dig  = counter_r;

  for (genvar c = 0; c < kcw_pkg::MAX_LEVELS; c++) begin : g_lvl
    kcw_pkg::depth_t idx;
    logic            active;

    assign idx    = depth - kcw_pkg::lvl_of(c);
    assign active = (kcw_pkg::lvl_of(c) <= depth);

    assign changed[c]   = active & (diff_dig[idx[kcw_pkg::LVL_IDX_BITS-1:0]] != 2'b00);
    assign ctl[c].digit = cnt_dig[idx[kcw_pkg::LVL_IDX_BITS-1:0]];
    assign fin_v[c]     = done[c] & (kcw_pkg::lvl_of(c) == depth);

    if (c == 0) begin : g_head
      assign ctl[c].start = kick_r[c];
      kcw_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_i    (ctl[c]),
        .parent_i (base_seg_r),
        .seg_o    (segs[c]),
        .done_o   (done[c])
      );
    end else begin : g_body
      assign ctl[c].start = kick_r[c] | (done[c-1] & active);
      kcw_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_i    (ctl[c]),
        .parent_i (segs[c-1]),
        .seg_o    (segs[c]),
        .done_o   (done[c])
      );
    end
  end

  // highest changed digit starts the chain
  assign sel      = wrap ? kcw_pkg::FIRST_LEVEL : changed;
  assign kick_nxt = (depth != '0) ? (sel & (~sel + 1'b1)) : '0;
  assign fin      = |fin_v;

  assign out_idx    = depth - 1'b1;
  assign result_seg = (depth == '0) ? base_seg_r
                                    : segs[out_idx[kcw_pkg::LVL_IDX_BITS-1:0]];
  assign out_free   = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kcw_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (depth == '0) ? kcw_pkg::S_HOLD : kcw_pkg::S_RUN;
        end
      end
      kcw_pkg::S_RUN: begin
        if (fin) begin
          state_nxt = kcw_pkg::S_HOLD;
        end
      end
      kcw_pkg::S_HOLD: begin
        if (out_free) begin
          state_nxt = kcw_pkg::S_IDLE;
        end
      end
      default: state_nxt = kcw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      kcw_pkg::S_IDLE: in_ready = 1'b1;
      kcw_pkg::S_HOLD: load_out = out_free;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kcw_pkg::S_IDLE;
      started_r   <= 1'b0;
      counter_r   <= '0;
      kick_r      <= '0;
      out_valid_r <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      levels_r    <= '0;
    end else begin
      state_r <= state_nxt;
      kick_r  <= accept ? kick_nxt : '0;
      if (cfg_we) begin
        case (kcw_pkg::cfg_idx_t'(cfg_index))
          kcw_pkg::CFG_START_X: begin
            start_x_r <= cfg_data;
            started_r <= 1'b0;
          end
          kcw_pkg::CFG_START_Y: begin
            start_y_r <= cfg_data;
            started_r <= 1'b0;
          end
          kcw_pkg::CFG_END_X: begin
            end_x_r   <= cfg_data;
            started_r <= 1'b0;
          end
          kcw_pkg::CFG_END_Y: begin
            end_y_r   <= cfg_data;
            started_r <= 1'b0;
          end
          kcw_pkg::CFG_LEVELS: begin
            levels_r  <= cfg_data[kcw_pkg::LEVELS_BITS-1:0];
            started_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        counter_r <= n_nxt;
        started_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_flag_r <= (n_nxt == last);
      if (wrap) begin
        base_seg_r <= '{x1: start_x_r, y1: start_y_r, x2: end_x_r, y2: end_y_r};
      end
    end
    if (load_out) begin
      out_seg_r  <= result_seg;
      out_num_r  <= counter_r;
      out_last_r <= last_flag_r;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.from_x         = out_seg_r.x1;
  assign out_ch.from_y         = out_seg_r.y1;
  assign out_ch.to_x           = out_seg_r.x2;
  assign out_ch.to_y           = out_seg_r.y2;
  assign out_ch.segment_number = out_num_r;
  assign out_ch.last_segment   = out_last_r;

`ifndef SYNTH
  a_kick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(kick_r))
    else $error("more than one level cell kicked");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|done) |-> (state_r == kcw_pkg::S_RUN))
    else $error("level cell finished outside a walk step");

  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((kick_r != '0) || (state_r == kcw_pkg::S_HOLD)))
    else $error("accepted word started no level cell");
`endif

endmodule

@@ tb/kcw_walk_checker.sv @@
// Checker for the Koch segment walker: predicts every segment word and compares it.
module kcw_walk_checker
  import kcw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  kcw_in_if                        req_ch,
  kcw_out_if                       seg_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       words_seen,
  output int                       words_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam longint SIN60_MUL = 56756;

  typedef struct packed {
    coord_t fx;
    coord_t fy;
    coord_t tx;
    coord_t ty;
    cnt_t   num;
    logic   last;
  } seg_word_t;

  seg_t                   base_seg;
  seg_t                   level_seg [0:MAX_LEVELS];
  logic [LEVELS_BITS-1:0] lvl_reg;
  cnt_t                   walk_cnt;
  bit                     walk_on;
  seg_word_t              owed_words [$];
  int                     mism;
  int                     seen;

  function automatic coord_t wrap_c(input longint v);
    return coord_t'(v);
  endfunction

  function automatic longint sin60(input longint d);
    return (d * SIN60_MUL) >>> 16;
  endfunction

  // one child of a segment at thirds; the middle third is turned +60 degrees
  function automatic seg_t split_third(input seg_t p, input logic [1:0] digit);
    longint x1, y1, x2, y2, dx, dy;
    coord_t px [0:4];
    coord_t py [0:4];
    int     d;
    seg_t   q;
    x1 = longint'($signed(p.x1));
    y1 = longint'($signed(p.y1));
    x2 = longint'($signed(p.x2));
    y2 = longint'($signed(p.y2));
    dx = (x2 - x1) / 3;
    dy = (y2 - y1) / 3;
    px[0] = p.x1;
    py[0] = p.y1;
    px[1] = wrap_c(x1 + dx);
    py[1] = wrap_c(y1 + dy);
    px[2] = wrap_c(longint'($signed(px[1])) + (dx >>> 1) - sin60(dy));
    py[2] = wrap_c(longint'($signed(py[1])) + sin60(dx) + (dy >>> 1));
    px[3] = wrap_c(x2 - dx);
    py[3] = wrap_c(y2 - dy);
    px[4] = p.x2;
    py[4] = p.y2;
    d = int'(digit);
    q.x1 = px[d];
    q.y1 = py[d];
    q.x2 = px[d + 1];
    q.y2 = py[d + 1];
    return q;
  endfunction

  // advance the walk by one request and give the segment it yields
  function automatic seg_word_t next_word(input logic rs);
    int unsigned depth, first, k;
    logic [31:0] last_n, n, diff;
    seg_word_t   w;
    depth  = (lvl_reg > MAX_LEVELS) ? MAX_LEVELS : lvl_reg;
    last_n = (32'd1 << (2 * depth)) - 32'd1;
    if (rs || !walk_on || 32'(walk_cnt) >= last_n) begin
      n             = '0;
      first         = 1;
      level_seg[0]  = base_seg;
    end else begin
      n     = 32'(walk_cnt) + 32'd1;
      diff  = n ^ 32'(walk_cnt);
      first = depth;
      for (k = depth; k >= 1; k--) begin
        if (((diff >> (2 * (depth - k))) & 32'd3) != 0) first = k;
      end
    end
    for (k = first; k <= depth; k++)
      level_seg[k] = split_third(level_seg[k - 1], 2'(n >> (2 * (depth - k))));
    walk_cnt = n[CNT_BITS-1:0];
    walk_on  = 1'b1;
    w.fx   = level_seg[depth].x1;
    w.fy   = level_seg[depth].y1;
    w.tx   = level_seg[depth].x2;
    w.ty   = level_seg[depth].y2;
    w.num  = n[CNT_BITS-1:0];
    w.last = (n == last_n);
    return w;
  endfunction

  always @(posedge clk) begin
    seg_word_t got, want;
    if (!rst_n) begin
      base_seg = '0;
      lvl_reg  = '0;
      walk_cnt = '0;
      walk_on  = 1'b0;
      owed_words.delete();
      mism = 0;
      seen = 0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        got.fx   = seg_ch.from_x;
        got.fy   = seg_ch.from_y;
        got.tx   = seg_ch.to_x;
        got.ty   = seg_ch.to_y;
        got.num  = seg_ch.segment_number;
        got.last = seg_ch.last_segment;
        seen++;
        if (owed_words.size() == 0) begin
          mism++;
          if (mism <= MAX_REPORTS)
            $display("%0t: unexpected word n %0d from (%0d,%0d) to (%0d,%0d) last %0b",
                     $time, got.num, $signed(got.fx), $signed(got.fy),
                     $signed(got.tx), $signed(got.ty), got.last);
        end else begin
          want = owed_words.pop_front();
          if (want.fx !== got.fx || want.fy !== got.fy || want.tx !== got.tx ||
              want.ty !== got.ty || want.num !== got.num || want.last !== got.last) begin
            mism++;
            if (mism <= MAX_REPORTS) begin
              $display("%0t: word %0d exp n %0d from (%0d,%0d) to (%0d,%0d) last %0b",
                       $time, seen, want.num, $signed(want.fx), $signed(want.fy),
                       $signed(want.tx), $signed(want.ty), want.last);
              $display("%0t: word %0d got n %0d from (%0d,%0d) to (%0d,%0d) last %0b",
                       $time, seen, got.num, $signed(got.fx), $signed(got.fy),
                       $signed(got.tx), $signed(got.ty), got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_X: base_seg.x1 = cfg_data;
          CFG_START_Y: base_seg.y1 = cfg_data;
          CFG_END_X:   base_seg.x2 = cfg_data;
          CFG_END_Y:   base_seg.y2 = cfg_data;
          CFG_LEVELS:  lvl_reg     = cfg_data[LEVELS_BITS-1:0];
          default: ;
        endcase
        // only a write to a known register drops the walk
        if (cfg_index <= CFG_LEVELS) walk_on = 1'b0;
      end
      if (req_ch.valid && req_ch.ready)
        owed_words.push_back(next_word(req_ch.restart));
    end
    fail_count <= mism;
    words_seen <= seen;
    words_owed <= owed_words.size();
  end

endmodule

@@ tb/koch_curve_segment_walker_unit_tb.sv @@
// Testbench top for the Koch segment walker: stimulus, handshake pressure and verdict.
module koch_curve_segment_walker_unit_tb;
  import kcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_REQS  = 750;
  localparam int CALM_REQS   = 100;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int RESET_CYCLES = 8;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int fail_count, words_seen, words_owed;
  int reqs_sent     = 0;
  int restarts_sent = 0;
  int phases        = 0;
  int deepest       = 0;
  int src_odds      = 0;
  int stall_odds    = 0;
  bit calm          = 1'b0;
  bit hold_req      = 1'b0;
  logic [LEVELS_BITS-1:0] cur_lv = '0;

  kcw_in_if  req_if ();
  kcw_out_if seg_if ();

  always #1 clk = ~clk;

  koch_curve_segment_walker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (seg_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kcw_walk_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ch     (req_if),
    .seg_ch     (seg_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .words_seen (words_seen),
    .words_owed (words_owed)
  );

  function automatic logic [CFG_DATA_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(COORD_BITS-1){1'b1}}};
      1: return {1'b1, {(COORD_BITS-1){1'b0}}};
      2: return '0;
      3, 4: return CFG_DATA_BITS'($urandom);
      default: return CFG_DATA_BITS'($urandom_range(0, 32767)) - CFG_DATA_BITS'(16384);
    endcase
  endfunction

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_word(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_LEVELS) cur_lv = data[LEVELS_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic send_req(input logic rs);
    req_if.valid   <= 1'b1;
    req_if.restart <= rs;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    reqs_sent++;
    if (rs) restarts_sent++;
  endtask

  // valid stays high after the last word; wait_drained lowers it
  task automatic run_reqs(input int count, input int restart_odds, input bit lead_restart);
    logic rs;
    for (int i = 0; i < count; i++) begin
      rs = (i == 0 && lead_restart) ||
           (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
      send_req(rs);
      if (i < count - 1 && !calm && src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'($urandom);
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (words_seen < reqs_sent) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    seg_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        seg_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        seg_if.ready <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall = $urandom_range(1, 5);
        seg_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        seg_if.ready <= 1'b1;
      end else begin
        seg_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (seg_if.valid && seg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int count, depth, span, half;
    bit wrote;
    logic [LEVELS_BITS-1:0]   lv;
    logic [CFG_DATA_BITS-1:0] lv_word;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_odds   = 3;
    stall_odds = 4;

    // reset settings: depth 0, zero segment
    run_reqs(2, 0, 0);
    wait_drained();

    // coordinate extremes at depth 1, walk wraps past the last segment
    write_word(CFG_START_X, {1'b1, {(COORD_BITS-1){1'b0}}});
    write_word(CFG_START_Y, {1'b0, {(COORD_BITS-1){1'b1}}});
    write_word(CFG_END_X, {1'b0, {(COORD_BITS-1){1'b1}}});
    write_word(CFG_END_Y, {1'b1, {(COORD_BITS-1){1'b0}}});
    write_word(CFG_LEVELS, CFG_DATA_BITS'(1));
    cfg_we <= 1'b0;
    run_reqs(5, 0, 0);
    wait_drained();

    // depth 2: carry into the upper digit, ignored index mid-walk, restart
    write_word(CFG_START_X, '0);
    write_word(CFG_START_Y, '0);
    write_word(CFG_END_X, CFG_DATA_BITS'(24'h002400));
    write_word(CFG_END_Y, CFG_DATA_BITS'(24'hFFF400));
    write_word(CFG_LEVELS, CFG_DATA_BITS'(2));
    cfg_we <= 1'b0;
    run_reqs(6, 0, 0);
    wait_drained();
    write_word(CFG_LEVELS + CFG_IDX_BITS'(1), CFG_DATA_BITS'(24'hA5A5A5));
    cfg_we <= 1'b0;
    run_reqs(1, 0, 0);
    run_reqs(4, 0, 1);
    wait_drained();

    // depth above the maximum saturates
    write_word(CFG_LEVELS, CFG_DATA_BITS'(24'h5A5A5B));
    cfg_we <= 1'b0;
    run_reqs(3, 0, 0);
    wait_drained();

    write_word(CFG_START_X, rand_coord());
    write_word(CFG_START_Y, rand_coord());
    write_word(CFG_LEVELS, CFG_DATA_BITS'(24'hFFFFF0));
    cfg_we <= 1'b0;
    run_reqs(2, 0, 1);
    wait_drained();

    while (reqs_sent < TOTAL_REQS) begin
      phases++;
      calm       = (reqs_sent >= TOTAL_REQS - CALM_REQS);
      src_odds   = calm ? 0 : $urandom_range(0, 5);
      stall_odds = calm ? 0 : $urandom_range(0, 5);

      wrote = 1'b0;
      if ($urandom_range(0, 1)) begin write_word(CFG_START_X, rand_coord()); wrote = 1'b1; end
      if ($urandom_range(0, 1)) begin write_word(CFG_START_Y, rand_coord()); wrote = 1'b1; end
      if ($urandom_range(0, 1)) begin write_word(CFG_END_X, rand_coord()); wrote = 1'b1; end
      if ($urandom_range(0, 1)) begin write_word(CFG_END_Y, rand_coord()); wrote = 1'b1; end
      if (!wrote || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       lv = '0;
          1, 2:    lv = LEVELS_BITS'(1);
          3, 4:    lv = LEVELS_BITS'(2);
          5, 6:    lv = LEVELS_BITS'(3);
          7:       lv = LEVELS_BITS'(4);
          8:       lv = LEVELS_BITS'($urandom_range(5, MAX_LEVELS));
          default: lv = LEVELS_BITS'($urandom_range(MAX_LEVELS, 15));
        endcase
        lv_word = CFG_DATA_BITS'($urandom);
        lv_word[LEVELS_BITS-1:0] = lv;
        write_word(CFG_LEVELS, lv_word);
      end
      if ($urandom_range(0, 7) == 0)
        write_word(CFG_LEVELS + CFG_IDX_BITS'($urandom_range(1, 3)), CFG_DATA_BITS'($urandom));
      cfg_we <= 1'b0;

      depth = (cur_lv > MAX_LEVELS) ? MAX_LEVELS : cur_lv;
      if (depth > deepest) deepest = depth;
      span  = 1 << (2 * depth);
      count = (span <= 64) ? span + $urandom_range(1, span + 2) : $urandom_range(10, 40);

      // receiver stalls long while requests keep coming
      if (phases == 3) begin
        hold_req = 1'b1;
        if (count < 24) count = 24;
      end

      if (phases == 5) begin
        half = count / 2;
        run_reqs(half, 16, 0);
        wait_drained();
        run_reqs(count - half, 16, 0);
      end else begin
        run_reqs(count, 16, 0);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d with restart) over %0d random settings, depths up to %0d.",
             reqs_sent, restarts_sent, phases, deepest);
    $display("Checked %0d segment words against the prediction, %0d mismatched.",
             words_seen, fail_count);
    if (words_owed != 0) $display("%0d predicted segment words never arrived", words_owed);
    if (fail_count == 0 && words_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
